// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit: channel words,
// operation and status codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package rau_pkg;

    // magnitudes are kept as 64-bit unsigned values and wrap like the products
    localparam int MAG_W = 64;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic neg;
        t_mag mag;
    } t_sm;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_NEG  = 3'd5,
        OP_CMP  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] lhs_num;
        logic signed [31:0] lhs_den;
        logic signed [31:0] rhs_num;
        logic signed [31:0] rhs_den;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
        logic               less;
        logic               equal;
    } t_out_word;

    // operand registers of the datapath
    typedef enum logic [1:0] {
        R_AN = 2'd0,
        R_AD = 2'd1,
        R_BN = 2'd2,
        R_BD = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        C_NOP,
        C_LOAD,
        C_NEGA,
        C_NEGB,
        C_MUL,
        C_SUM,
        C_ZERO,
        C_GCD,
        C_DIV,
        C_OUT,
        C_ERRZ,
        C_EQ,
        C_LESS
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_reg    dst;
        t_reg    src_a;
        t_reg    src_b;
        logic    pair;     // 0: left fraction, 1: right fraction
    } t_cmd;

    typedef struct packed {
        logic an_zero;
        logic ad_zero;
        logic bn_zero;
        logic bd_zero;
        logic mul_done;
        logic gcd_done;
        logic div_done;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_NEGA,
        S_NEGB,
        S_M1,
        S_M1W,
        S_M2,
        S_M2W,
        S_M3,
        S_M3W,
        S_SUM,
        S_FCHK,
        S_RED,
        S_GCDW,
        S_DIV,
        S_DIVW,
        S_FOUT,
        S_ERRZ,
        S_EQ,
        S_LESS,
        S_DONE
    } t_state;

endpackage

// ===== rtl/rau_stream_if.sv =====
// ----------------------------------------------------------------------------
// rau_stream_if
// Valid/ready channels of the rational arithmetic unit: operand words in,
// result words out.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic               valid;
    logic               ready;
    rau_pkg::t_in_word  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    rau_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shift-add multiplier, binary GCD unit, dual restoring
// divider and result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rau_pkg::t_cmd      i_cmd,
    input  rau_pkg::t_in_word  i_in_word,
    output rau_pkg::t_stat     o_stat,
    output rau_pkg::t_out_word o_out_word
);

    localparam int MAG_W    = rau_pkg::MAG_W;
    localparam int MB       = VALUE_WIDTH + 1;
    localparam int MCW      = $clog2(MB);
    localparam int DIV_BITS = (2 * VALUE_WIDTH + 2 > MAG_W) ? MAG_W : 2 * VALUE_WIDTH + 2;
    localparam int DCW      = $clog2(DIV_BITS);
    localparam rau_pkg::t_mag LIM = rau_pkg::t_mag'(1) << (VALUE_WIDTH - 1);

    // two's complement field to sign and magnitude
    function automatic rau_pkg::t_sm from_field(input logic [31:0] f);
        rau_pkg::t_sm r;
        rau_pkg::t_mag u;
        u = rau_pkg::t_mag'(f[VALUE_WIDTH-1:0]);
        if (f[VALUE_WIDTH-1]) begin
            r.neg = 1'b1;
            r.mag = (rau_pkg::t_mag'(1) << VALUE_WIDTH) - u;
        end else begin
            r.neg = 1'b0;
            r.mag = u;
        end
        return r;
    endfunction

    function automatic rau_pkg::t_sm sm_neg(input rau_pkg::t_sm a);
        rau_pkg::t_sm r;
        r = a;
        if (a.mag != '0) begin
            r.neg = !a.neg;
        end
        return r;
    endfunction

    function automatic rau_pkg::t_sm sm_add(input rau_pkg::t_sm a, input rau_pkg::t_sm b);
        rau_pkg::t_sm r;
        if (a.neg == b.neg) begin
            r.mag = a.mag + b.mag;
            r.neg = a.neg;
        end else if (a.mag >= b.mag) begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
        end else begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    rau_pkg::t_sm r_an, r_ad, r_bn, r_bd;
    rau_pkg::t_sm n_an, n_ad, n_bn, n_bd;
    rau_pkg::t_out_word r_out, n_out;

    // multiplier state
    logic             r_mul_busy;
    logic             r_mul_done;
    logic [MCW-1:0]   r_mul_cnt;
    rau_pkg::t_mag    r_mul_a;
    logic [MB-1:0]    r_mul_b;
    rau_pkg::t_mag    r_mul_acc;
    logic             r_mul_neg;
    rau_pkg::t_reg    r_mul_dst;

    // gcd state
    logic             r_gcd_busy;
    logic             r_gcd_done;
    rau_pkg::t_mag    r_gx, r_gy, r_g;
    logic [6:0]       r_gk;

    // divider state
    logic             r_div_busy;
    logic             r_div_done;
    logic             r_div_pair;
    logic [DCW-1:0]   r_div_cnt;
    rau_pkg::t_mag    r_qn, r_qd;
    logic [MAG_W:0]   r_rn, r_rd;

    rau_pkg::t_sm     src_a, src_b, add_res, sel_n, sel_d;
    rau_pkg::t_mag    mul_acc_nx;
    logic             mul_last;
    logic             div_last;
    logic [MAG_W:0]   tn, td, gx;
    logic             gen, ged;
    rau_pkg::t_mag    qn_nx, qd_nx;
    logic             ovf;

    // operand selection for the multiplier
    always_comb begin
        case (i_cmd.src_a)
            rau_pkg::R_AN: src_a = r_an;
            rau_pkg::R_AD: src_a = r_ad;
            rau_pkg::R_BN: src_a = r_bn;
            default:       src_a = r_bd;
        endcase
        case (i_cmd.src_b)
            rau_pkg::R_AN: src_b = r_an;
            rau_pkg::R_AD: src_b = r_ad;
            rau_pkg::R_BN: src_b = r_bn;
            default:       src_b = r_bd;
        endcase
    end

    // pair chosen for reduction
    assign sel_n = i_cmd.pair ? r_bn : r_an;
    assign sel_d = i_cmd.pair ? r_bd : r_ad;

    // shared signed adder: sum, or difference for compare
    assign add_res = sm_add(r_an, (i_cmd.op == rau_pkg::C_LESS) ? sm_neg(r_bn) : r_bn);

    // multiplier step
    assign mul_acc_nx = r_mul_acc + (r_mul_b[0] ? r_mul_a : '0);
    assign mul_last   = r_mul_busy && (r_mul_cnt == MCW'(MB - 1));

    // divider step, numerator and denominator side by side
    assign gx    = {1'b0, r_g};
    assign tn    = {r_rn[MAG_W-1:0], r_qn[DIV_BITS-1]};
    assign td    = {r_rd[MAG_W-1:0], r_qd[DIV_BITS-1]};
    assign gen   = (tn >= gx);
    assign ged   = (td >= gx);
    assign qn_nx = {r_qn[MAG_W-2:0], gen};
    assign qd_nx = {r_qd[MAG_W-2:0], ged};
    assign div_last = r_div_busy && (r_div_cnt == DCW'(DIV_BITS - 1));

    // range check of the reduced left pair
    assign ovf = (r_ad.mag > LIM - 1) || (r_an.mag > (r_an.neg ? LIM : LIM - 1));

    // operand register next values
    always_comb begin
        n_an = r_an;
        n_ad = r_ad;
        n_bn = r_bn;
        n_bd = r_bd;
        case (i_cmd.op)
            rau_pkg::C_LOAD: begin
                n_an = from_field(i_in_word.lhs_num);
                n_ad = from_field(i_in_word.lhs_den);
                n_bn = from_field(i_in_word.rhs_num);
                n_bd = from_field(i_in_word.rhs_den);
            end
            rau_pkg::C_NEGA: n_an = sm_neg(r_an);
            rau_pkg::C_NEGB: n_bn = sm_neg(r_bn);
            rau_pkg::C_SUM:  n_an = add_res;
            rau_pkg::C_ZERO: begin
                if (i_cmd.pair) begin
                    n_bn = '{neg: 1'b0, mag: '0};
                    n_bd = '{neg: 1'b0, mag: rau_pkg::t_mag'(1)};
                end else begin
                    n_an = '{neg: 1'b0, mag: '0};
                    n_ad = '{neg: 1'b0, mag: rau_pkg::t_mag'(1)};
                end
            end
            default: ;
        endcase
        if (mul_last) begin
            case (r_mul_dst)
                rau_pkg::R_AN: n_an = '{neg: r_mul_neg && (mul_acc_nx != '0), mag: mul_acc_nx};
                rau_pkg::R_AD: n_ad = '{neg: r_mul_neg && (mul_acc_nx != '0), mag: mul_acc_nx};
                rau_pkg::R_BN: n_bn = '{neg: r_mul_neg && (mul_acc_nx != '0), mag: mul_acc_nx};
                default:       n_bd = '{neg: r_mul_neg && (mul_acc_nx != '0), mag: mul_acc_nx};
            endcase
        end
        if (div_last) begin
            if (r_div_pair) begin
                n_bn = '{neg: r_bn.neg ^ r_bd.neg,
                         mag: rau_pkg::t_mag'(qn_nx[DIV_BITS-1:0])};
                n_bd = '{neg: 1'b0, mag: rau_pkg::t_mag'(qd_nx[DIV_BITS-1:0])};
            end else begin
                n_an = '{neg: r_an.neg ^ r_ad.neg,
                         mag: rau_pkg::t_mag'(qn_nx[DIV_BITS-1:0])};
                n_ad = '{neg: 1'b0, mag: rau_pkg::t_mag'(qd_nx[DIV_BITS-1:0])};
            end
        end
    end

    // result word next value
    always_comb begin
        n_out = r_out;
        case (i_cmd.op)
            rau_pkg::C_LOAD: n_out = '0;
            rau_pkg::C_ERRZ: n_out.status = rau_pkg::ST_ZERO_DEN;
            rau_pkg::C_OUT: begin
                if (ovf) begin
                    n_out.status = rau_pkg::ST_OVERFLOW;
                end else begin
                    n_out.res_num = r_an.neg ? (32'd0 - r_an.mag[31:0]) : r_an.mag[31:0];
                    n_out.res_den = r_ad.mag[30:0];
                end
            end
            rau_pkg::C_EQ: n_out.equal = (r_an.neg == r_bn.neg) && (r_an.mag == r_bn.mag)
                                         && (r_ad.mag == r_bd.mag);
            rau_pkg::C_LESS: n_out.less = (add_res.mag != '0) && add_res.neg;
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_an  <= n_an;
        r_ad  <= n_ad;
        r_bn  <= n_bn;
        r_bd  <= n_bd;
        r_out <= n_out;
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_done <= 1'b0;
        end else begin
            r_mul_done <= mul_last;
            if (i_cmd.op == rau_pkg::C_MUL) begin
                r_mul_busy <= 1'b1;
            end else if (mul_last) begin
                r_mul_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rau_pkg::C_MUL) begin
            r_mul_cnt <= '0;
            r_mul_a   <= src_a.mag;
            r_mul_b   <= src_b.mag[MB-1:0];
            r_mul_acc <= '0;
            r_mul_neg <= src_a.neg ^ src_b.neg;
            r_mul_dst <= i_cmd.dst;
        end else if (r_mul_busy) begin
            r_mul_cnt <= r_mul_cnt + MCW'(1);
            r_mul_a   <= r_mul_a << 1;
            r_mul_b   <= r_mul_b >> 1;
            r_mul_acc <= mul_acc_nx;
        end
    end

    // binary gcd, one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcd_busy <= 1'b0;
            r_gcd_done <= 1'b0;
        end else begin
            r_gcd_done <= 1'b0;
            if (i_cmd.op == rau_pkg::C_GCD) begin
                r_gcd_busy <= 1'b1;
            end else if (r_gcd_busy && (r_gx == '0)) begin
                r_gcd_busy <= 1'b0;
                r_gcd_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rau_pkg::C_GCD) begin
            r_gx <= sel_n.mag;
            r_gy <= sel_d.mag;
            r_gk <= '0;
        end else if (r_gcd_busy) begin
            if (r_gx == '0) begin
                r_g <= r_gy << r_gk;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 7'd1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= (r_gx - r_gy) >> 1;
            end else begin
                r_gy <= (r_gy - r_gx) >> 1;
            end
        end
    end

    // restoring divider, both parts by the gcd, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= div_last;
            if (i_cmd.op == rau_pkg::C_DIV) begin
                r_div_busy <= 1'b1;
            end else if (div_last) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rau_pkg::C_DIV) begin
            r_div_pair <= i_cmd.pair;
            r_div_cnt  <= '0;
            r_qn       <= sel_n.mag;
            r_qd       <= sel_d.mag;
            r_rn       <= '0;
            r_rd       <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + DCW'(1);
            r_qn      <= qn_nx;
            r_qd      <= qd_nx;
            r_rn      <= gen ? (tn - gx) : tn;
            r_rd      <= ged ? (td - gx) : td;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.an_zero  = (r_an.mag == '0);
        o_stat.ad_zero  = (r_ad.mag == '0);
        o_stat.bn_zero  = (r_bn.mag == '0);
        o_stat.bd_zero  = (r_bd.mag == '0);
        o_stat.mul_done = r_mul_done;
        o_stat.gcd_done = r_gcd_done;
        o_stat.div_done = r_div_done;
    end

    assign o_out_word = r_out;

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit: walks each operation through
// its zero checks, products, reductions and result steps.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [2:0]     i_op,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);

    rau_pkg::t_state r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic            r_pair, n_pair;
    rau_pkg::t_op    op;
    logic            den_err;
    logic            red_zero;
    rau_pkg::t_state after_red;

    assign op = rau_pkg::t_op'(r_op);

    // zero denominator checks made before any product
    always_comb begin
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_CMP:
                den_err = i_stat.ad_zero || i_stat.bd_zero;
            rau_pkg::OP_DIV:
                den_err = i_stat.ad_zero || i_stat.bd_zero || i_stat.bn_zero;
            default:
                den_err = 1'b0;
        endcase
    end

    assign red_zero = r_pair ? i_stat.bn_zero : i_stat.an_zero;

    // where to go once a fraction is reduced
    always_comb begin
        if (op == rau_pkg::OP_CMP) begin
            after_red = r_pair ? rau_pkg::S_EQ : rau_pkg::S_RED;
        end else begin
            after_red = rau_pkg::S_FOUT;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pair  = r_pair;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_state = rau_pkg::S_CHECK;
                end
            end
            rau_pkg::S_CHECK: begin
                n_pair = 1'b0;
                if (den_err) begin
                    n_state = rau_pkg::S_ERRZ;
                end else begin
                    case (op)
                        rau_pkg::OP_NORM: n_state = rau_pkg::S_FCHK;
                        rau_pkg::OP_NEG:  n_state = rau_pkg::S_NEGA;
                        rau_pkg::OP_SUB:  n_state = rau_pkg::S_NEGB;
                        rau_pkg::OP_ADD,
                        rau_pkg::OP_MUL,
                        rau_pkg::OP_DIV:  n_state = rau_pkg::S_M1;
                        rau_pkg::OP_CMP:  n_state = rau_pkg::S_RED;
                        default:          n_state = rau_pkg::S_DONE;
                    endcase
                end
            end
            rau_pkg::S_NEGA: n_state = rau_pkg::S_FCHK;
            rau_pkg::S_NEGB: n_state = rau_pkg::S_M1;
            rau_pkg::S_M1:   n_state = rau_pkg::S_M1W;
            rau_pkg::S_M1W: begin
                if (i_stat.mul_done) begin
                    n_state = rau_pkg::S_M2;
                end
            end
            rau_pkg::S_M2:   n_state = rau_pkg::S_M2W;
            rau_pkg::S_M2W: begin
                if (i_stat.mul_done) begin
                    case (op)
                        rau_pkg::OP_ADD, rau_pkg::OP_SUB: n_state = rau_pkg::S_M3;
                        rau_pkg::OP_CMP:                  n_state = rau_pkg::S_LESS;
                        default:                          n_state = rau_pkg::S_FCHK;
                    endcase
                end
            end
            rau_pkg::S_M3:   n_state = rau_pkg::S_M3W;
            rau_pkg::S_M3W: begin
                if (i_stat.mul_done) begin
                    n_state = rau_pkg::S_SUM;
                end
            end
            rau_pkg::S_SUM:  n_state = rau_pkg::S_FCHK;
            rau_pkg::S_FCHK: begin
                n_pair  = 1'b0;
                n_state = i_stat.ad_zero ? rau_pkg::S_ERRZ : rau_pkg::S_RED;
            end
            rau_pkg::S_RED: begin
                if (red_zero) begin
                    n_state = after_red;
                    n_pair  = 1'b1;
                end else begin
                    n_state = rau_pkg::S_GCDW;
                end
            end
            rau_pkg::S_GCDW: begin
                if (i_stat.gcd_done) begin
                    n_state = rau_pkg::S_DIV;
                end
            end
            rau_pkg::S_DIV:  n_state = rau_pkg::S_DIVW;
            rau_pkg::S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = after_red;
                    n_pair  = 1'b1;
                end
            end
            rau_pkg::S_EQ:   n_state = rau_pkg::S_M1;
            rau_pkg::S_FOUT,
            rau_pkg::S_ERRZ,
            rau_pkg::S_LESS: n_state = rau_pkg::S_DONE;
            rau_pkg::S_DONE: begin
                if (i_out_ready) begin
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_cmd.op    = rau_pkg::C_NOP;
        o_cmd.dst   = rau_pkg::R_AN;
        o_cmd.src_a = rau_pkg::R_AN;
        o_cmd.src_b = rau_pkg::R_BD;
        o_cmd.pair  = r_pair;
        o_in_ready  = (r_state == rau_pkg::S_IDLE);
        o_out_valid = (r_state == rau_pkg::S_DONE);
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = rau_pkg::C_LOAD;
                end
            end
            rau_pkg::S_NEGA: o_cmd.op = rau_pkg::C_NEGA;
            rau_pkg::S_NEGB: o_cmd.op = rau_pkg::C_NEGB;
            rau_pkg::S_M1: begin
                o_cmd.op    = rau_pkg::C_MUL;
                o_cmd.dst   = rau_pkg::R_AN;
                o_cmd.src_a = rau_pkg::R_AN;
                o_cmd.src_b = (op == rau_pkg::OP_MUL) ? rau_pkg::R_BN : rau_pkg::R_BD;
            end
            rau_pkg::S_M2: begin
                o_cmd.op = rau_pkg::C_MUL;
                case (op)
                    rau_pkg::OP_MUL: begin
                        o_cmd.dst   = rau_pkg::R_AD;
                        o_cmd.src_a = rau_pkg::R_AD;
                        o_cmd.src_b = rau_pkg::R_BD;
                    end
                    rau_pkg::OP_DIV: begin
                        o_cmd.dst   = rau_pkg::R_AD;
                        o_cmd.src_a = rau_pkg::R_AD;
                        o_cmd.src_b = rau_pkg::R_BN;
                    end
                    default: begin
                        o_cmd.dst   = rau_pkg::R_BN;
                        o_cmd.src_a = rau_pkg::R_BN;
                        o_cmd.src_b = rau_pkg::R_AD;
                    end
                endcase
            end
            rau_pkg::S_M3: begin
                o_cmd.op    = rau_pkg::C_MUL;
                o_cmd.dst   = rau_pkg::R_AD;
                o_cmd.src_a = rau_pkg::R_AD;
                o_cmd.src_b = rau_pkg::R_BD;
            end
            rau_pkg::S_SUM:  o_cmd.op = rau_pkg::C_SUM;
            rau_pkg::S_RED:  o_cmd.op = red_zero ? rau_pkg::C_ZERO : rau_pkg::C_GCD;
            rau_pkg::S_DIV:  o_cmd.op = rau_pkg::C_DIV;
            rau_pkg::S_FOUT: o_cmd.op = rau_pkg::C_OUT;
            rau_pkg::S_ERRZ: o_cmd.op = rau_pkg::C_ERRZ;
            rau_pkg::S_EQ:   o_cmd.op = rau_pkg::C_EQ;
            rau_pkg::S_LESS: o_cmd.op = rau_pkg::C_LESS;
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_op    <= '0;
            r_pair  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_pair  <= n_pair;
        end
    end

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// One operation on two signed fractions per word, giving a reduced fraction or compare flags.
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one operand word: operation, lhs_num/lhs_den, rhs_num/rhs_den.
//   o_out carries one result word per operand word: res_num/res_den reduced,
//   sign in the numerator, status, and less/equal for compare.
//   one word is in flight at a time: i_in.ready is high only while idle.
// sequence: each product runs in the shift-add multiplier, each reduction
//   in the binary gcd unit and then the divider (skipped for a zero numerator).
//   normalize and negate make one reduction, multiply/divide two products
//   and one reduction, add/subtract three products, a sum and one reduction,
//   compare two reductions and two products.
//   a zero denominator found up front ends the word without any product.
// reset: synchronous active low, returns the sequencer to idle.
// stall: a result holds on o_out until taken; no new word is accepted before.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rau_in_if.sink     i_in,
    rau_out_if.source  o_out
);

    rau_pkg::t_cmd  cmd;
    rau_pkg::t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.payload.operation),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rau_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in.payload),
        .o_stat     (stat),
        .o_out_word (o_out.payload)
    );

`ifndef ASSERT_OFF
    // one word at a time: never ready while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // a taken result frees the block in the next cycle
    a_free_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> i_in.ready)
        else $error("block not idle after result taken");

    // an accepted word is not answered in the next cycle
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !o_out.valid)
        else $error("result too early");

    // error results carry no fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.payload.status == rau_pkg::ST_OVERFLOW
                         || o_out.payload.status == rau_pkg::ST_ZERO_DEN))
        |-> (o_out.payload.res_num == 32'sd0 && o_out.payload.res_den == 31'd0))
        else $error("error result with nonzero fraction");
`endif

endmodule

// ===== test/rational_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// Watches the operand and result channels of the rational arithmetic unit.
// Computes the reduced fraction, status and compare flags of every accepted
// operand word, queues them, and compares each result word field by field.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if    in_ch,
    rau_out_if   out_ch,
    output int   o_err_count,
    output int   o_pending,
    output int   o_checked
);

    localparam rau_pkg::t_mag HALF_RANGE = 64'h0000_0000_8000_0000;

    rau_pkg::t_out_word fraction_q[$];
    int                 err_count;
    int                 checked;

    assign o_err_count = err_count;
    assign o_pending   = fraction_q.size();
    assign o_checked   = checked;

    // operand field to sign and magnitude
    function automatic rau_pkg::t_sm field_sm(input logic [31:0] v);
        rau_pkg::t_sm r;
        r.neg = v[31];
        r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic rau_pkg::t_sm sm_times(input rau_pkg::t_sm a, input rau_pkg::t_sm b);
        rau_pkg::t_sm r;
        r.mag = a.mag * b.mag;
        r.neg = (r.mag != 0) && (a.neg != b.neg);
        return r;
    endfunction

    function automatic rau_pkg::t_sm sm_plus(input rau_pkg::t_sm a, input rau_pkg::t_sm b);
        rau_pkg::t_sm r;
        if (a.neg == b.neg) begin
            r.mag = a.mag + b.mag;
            r.neg = a.neg;
        end else if (a.mag >= b.mag) begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
        end else begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic rau_pkg::t_sm sm_flip(input rau_pkg::t_sm a);
        rau_pkg::t_sm r;
        r = a;
        if (a.mag != 0) r.neg = !a.neg;
        return r;
    endfunction

    function automatic rau_pkg::t_mag common_divisor(input rau_pkg::t_mag a,
                                                     input rau_pkg::t_mag b);
        rau_pkg::t_mag t;
        while (a != 0) begin
            t = b % a;
            b = a;
            a = t;
        end
        return b;
    endfunction

    // n/d in lowest terms, sign moved into the numerator
    function automatic void lowest_terms(input rau_pkg::t_sm n, input rau_pkg::t_sm d,
                                         output rau_pkg::t_sm rn, output rau_pkg::t_mag rd);
        rau_pkg::t_mag g;
        if (n.mag == 0) begin
            rn.neg = 1'b0;
            rn.mag = 0;
            rd     = 1;
        end else begin
            g      = common_divisor(n.mag, d.mag);
            rn.neg = (n.neg != d.neg);
            rn.mag = n.mag / g;
            rd     = d.mag / g;
        end
    endfunction

    function automatic rau_pkg::t_out_word reduced_word(input rau_pkg::t_sm n,
                                                        input rau_pkg::t_sm d);
        rau_pkg::t_out_word w;
        rau_pkg::t_sm       rn;
        rau_pkg::t_mag      rd;
        w = '0;
        if (d.mag == 0) begin
            w.status = rau_pkg::ST_ZERO_DEN;
            return w;
        end
        lowest_terms(n, d, rn, rd);
        if (rd > HALF_RANGE - 1 || rn.mag > (rn.neg ? HALF_RANGE : HALF_RANGE - 1)) begin
            w.status = rau_pkg::ST_OVERFLOW;
            return w;
        end
        w.res_num = rn.neg ? 32'(64'h1_0000_0000 - rn.mag) : rn.mag[31:0];
        w.res_den = rd[30:0];
        w.status  = rau_pkg::ST_OK;
        return w;
    endfunction

    function automatic rau_pkg::t_out_word fraction_result(input rau_pkg::t_in_word x);
        rau_pkg::t_out_word w;
        rau_pkg::t_sm       ln, ld, rn, rd, an, bn, lhs, rhs, diff;
        rau_pkg::t_mag      adn, bdn;
        w  = '0;
        ln = field_sm(x.lhs_num);
        ld = field_sm(x.lhs_den);
        rn = field_sm(x.rhs_num);
        rd = field_sm(x.rhs_den);
        case (x.operation)
            rau_pkg::OP_NORM: w = reduced_word(ln, ld);
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (ld.mag == 0 || rd.mag == 0) w.status = rau_pkg::ST_ZERO_DEN;
                else w = reduced_word(sm_plus(sm_times(ln, rd),
                            sm_times((x.operation == rau_pkg::OP_SUB) ? sm_flip(rn) : rn,
                                     ld)),
                            sm_times(ld, rd));
            end
            rau_pkg::OP_MUL: begin
                if (ld.mag == 0 || rd.mag == 0) w.status = rau_pkg::ST_ZERO_DEN;
                else w = reduced_word(sm_times(ln, rn), sm_times(ld, rd));
            end
            rau_pkg::OP_DIV: begin
                if (ld.mag == 0 || rd.mag == 0 || rn.mag == 0) w.status = rau_pkg::ST_ZERO_DEN;
                else w = reduced_word(sm_times(ln, rd), sm_times(ld, rn));
            end
            rau_pkg::OP_NEG: w = reduced_word(sm_flip(ln), ld);
            rau_pkg::OP_CMP: begin
                if (ld.mag == 0 || rd.mag == 0) begin
                    w.status = rau_pkg::ST_ZERO_DEN;
                end else begin
                    lowest_terms(ln, ld, an, adn);
                    lowest_terms(rn, rd, bn, bdn);
                    lhs     = an;
                    lhs.mag = an.mag * bdn;
                    rhs     = bn;
                    rhs.mag = bn.mag * adn;
                    diff    = sm_plus(lhs, sm_flip(rhs));
                    w.less  = (diff.mag != 0) && diff.neg;
                    w.equal = (an.neg == bn.neg) && (an.mag == bn.mag) && (adn == bdn);
                end
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
        err_count++;
    endtask

    // queue expected results, compare arriving result words
    always @(posedge i_clk) begin
        rau_pkg::t_out_word want;
        rau_pkg::t_out_word got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) fraction_q.push_back(fraction_result(in_ch.payload));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                checked++;
                if (fraction_q.size() == 0) begin
                    $display("mismatch at %0t: result word with none expected", $realtime);
                    err_count++;
                end else begin
                    want = fraction_q.pop_front();
                    if (got.res_num !== want.res_num) report("res_num", got.res_num, want.res_num);
                    if (got.res_den !== want.res_den) report("res_den", got.res_den, want.res_den);
                    if (got.status !== want.status) report("status", got.status, want.status);
                    if (got.less !== want.less) report("less", got.less, want.less);
                    if (got.equal !== want.equal) report("equal", got.equal, want.equal);
                end
            end
        end
    end

    initial begin
        err_count = 0;
        checked   = 0;
    end

endmodule

// ===== test/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives operand words into the rational arithmetic unit: a directed set of
// edge fractions per operation, then random words in bursts, while the
// result side stalls on its own pattern. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         N_RANDOM    = 1930;
    localparam int         CYCLE_LIMIT = 6_000_000;
    localparam logic [31:0] MIN_VAL    = 32'h8000_0000;
    localparam logic [31:0] MAX_VAL    = 32'h7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   pending;
    int   checked;
    int   cycles;
    int   sent;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit #(.VALUE_WIDTH(32)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rational_arithmetic_unit_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rational_arithmetic_unit test failed");
            $finish;
        end
    end

    // result side: changing stall pattern, one long hold-off early on
    initial begin
        int mode;
        int n;
        out_ch.ready <= 1'b0;
        n = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            n++;
            if (n == 20000) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            if (n % 97 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= ($urandom_range(0, 7) == 0);
                default: out_ch.ready <= (n % 5 != 0);
            endcase
        end
    end

    // one operand word, held until taken
    task automatic send_word(input logic [2:0] op, input logic [31:0] an, input logic [31:0] ad,
                             input logic [31:0] bn, input logic [31:0] bd);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= {op, an, ad, bn, bd};
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sent++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 6))
            0, 1: return 32'($signed($urandom_range(0, 80)) - 40);
            2: return 32'($signed($urandom_range(0, 20000)) - 10000);
            3: return $urandom();
            4: return $urandom_range(0, 1) ? MIN_VAL + $urandom_range(0, 3)
                                           : MAX_VAL - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(1, 3000)) * 360 *
                                ($urandom_range(0, 1) ? 1 : -1));
        endcase
    endfunction

    function automatic logic [31:0] rand_den();
        if ($urandom_range(0, 15) == 0) return 32'd0;
        return rand_value();
    endfunction

    initial begin
        logic [2:0] op;
        int         gap;
        int         burst;
        cycles        = 0;
        sent          = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edge fractions
        send_word(rau_pkg::OP_NORM, 32'd6, -32'sd4, 32'd0, 32'd1);
        send_word(rau_pkg::OP_NORM, 32'd0, 32'd5, 32'd0, 32'd0);
        send_word(rau_pkg::OP_NORM, 32'd7, 32'd0, 32'd1, 32'd1);
        send_word(rau_pkg::OP_NORM, MIN_VAL, 32'd1, 32'd0, 32'd1);
        send_word(rau_pkg::OP_NORM, MIN_VAL, -32'sd1, 32'd0, 32'd1);
        send_word(rau_pkg::OP_NORM, 32'd1, MIN_VAL, 32'd0, 32'd1);
        send_word(rau_pkg::OP_NORM, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
        send_word(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(rau_pkg::OP_ADD, MAX_VAL, 32'd1, MAX_VAL, 32'd1);
        send_word(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
        send_word(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, -32'sd2);
        send_word(rau_pkg::OP_SUB, MIN_VAL, 32'd1, MAX_VAL, 32'd1);
        send_word(rau_pkg::OP_MUL, 32'd2, 32'd3, -32'sd9, 32'd4);
        send_word(rau_pkg::OP_MUL, MAX_VAL, 32'd1, MAX_VAL, 32'd1);
        send_word(rau_pkg::OP_MUL, 32'd2, 32'd0, 32'd9, 32'd4);
        send_word(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'd0, 32'd4);
        send_word(rau_pkg::OP_DIV, -32'sd2, 32'd3, 32'd4, -32'sd9);
        send_word(rau_pkg::OP_NEG, MIN_VAL, 32'd1, 32'd0, 32'd1);
        send_word(rau_pkg::OP_NEG, 32'd5, -32'sd10, 32'd0, 32'd1);
        send_word(rau_pkg::OP_CMP, 32'd2, 32'd4, -32'sd3, -32'sd6);
        send_word(rau_pkg::OP_CMP, -32'sd1, 32'd3, 32'd1, 32'd3);
        send_word(rau_pkg::OP_CMP, MIN_VAL, 32'd1, MAX_VAL, 32'd1);
        send_word(rau_pkg::OP_CMP, 32'd1, 32'd3, 32'd1, 32'd0);
        send_word(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());

        // random words in bursts
        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                in_ch.valid <= 1'b0;
                while (checked != sent || pending != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                gap   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst--;
            op = ($urandom_range(0, 40) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
            send_word(op, rand_value(), rand_den(), rand_value(), rand_den());
        end
        in_ch.valid <= 1'b0;

        while (checked != sent || pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("sent %0d operand words over all operations, %0d result words checked",
                 sent, checked);
        if (err_count == 0) begin
            $display("rational_arithmetic_unit test passed");
        end else begin
            $display("rational_arithmetic_unit test failed");
        end
        $finish;
    end

endmodule
